// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types of the sorted-insert priority queue: table
// depth, field widths, status codes, request codes and the table entry.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH     = 64;
   localparam int AW        = $clog2(DEPTH);
   localparam int CW        = $clog2(DEPTH + 1);
   localparam int CAP_W     = 7;
   localparam int IDENT_W   = 16;
   localparam int PRIO_W    = 8;
   localparam int STAT_W    = 2;
   localparam int JOB_CNT_W = 7;

   typedef logic [STAT_W-1:0] status_type;

   localparam status_type STATUS_DONE      = 2'd0;
   localparam status_type STATUS_OVERFLOW  = 2'd1;
   localparam status_type STATUS_UNDERFLOW = 2'd2;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef struct packed {
      logic [IDENT_W-1:0] ident;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   typedef struct packed {
      logic            wr_en;
      logic [AW-1:0]   wr_addr;
      entry_type       wr_data;
      logic [AW-1:0]   rd_addr;
   } ram_req_type;

endpackage

// File: hdl/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: valid/ready handshake carrying one queue request.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [spq_pkg::IDENT_W-1:0] job_ident;
   logic [spq_pkg::PRIO_W-1:0]  job_priority;

   modport source (output valid, output req_type, output job_ident,
                   output job_priority, input ready);
   modport sink   (input valid, input req_type, input job_ident,
                   input job_priority, output ready);
   modport monitor (input valid, input ready, input req_type, input job_ident,
                    input job_priority);
endinterface

// File: hdl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: valid/ready handshake carrying one queue result.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [spq_pkg::STAT_W-1:0]    status;
   logic                          queue_empty;
   logic [spq_pkg::JOB_CNT_W-1:0] job_count;
   logic [spq_pkg::IDENT_W-1:0]   head_ident;
   logic [spq_pkg::PRIO_W-1:0]    head_priority;

   modport source (output valid, output status, output queue_empty,
                   output job_count, output head_ident, output head_priority,
                   input ready);
   modport sink   (input valid, input status, input queue_empty,
                   input job_count, input head_ident, input head_priority,
                   output ready);
   modport monitor (input valid, input ready, input status, input queue_empty,
                    input job_count, input head_ident, input head_priority);
endinterface

// File: hdl/sorted_insert_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Job queue kept sorted by ascending priority value in a 64-entry table;
// equal priorities keep arrival order. Insert and remove each return one
// result with status, count and the head job.
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        req_type, job_ident, job_priority
//   rsp_chan  out   valid/ready        status, queue_empty, job_count,
//                                      head_ident, head_priority
//   csr       in    csr_wr_en          csr_wr_data (capacity)
//
// An insert walks down from the tail, moving each entry that sorts after
// the new job up one slot, then writes the new job; an insert into an empty
// table writes slot 0 directly; a remove moves each entry above slot 0 down
// one slot; a rejected request leaves the table as it is. The table walk
// runs one slot a cycle through the single table port pair. The result is
// then held until rsp_chan is ready, and req_chan is not ready from
// acceptance until the result is taken.
// Reset clears the count and sets capacity to 64; table contents are not
// cleared, only slots below the count are read.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue (
   input  logic                      clock,
   input  logic                      reset,
   spq_req_if.sink                   req_chan,
   spq_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [spq_pkg::CAP_W-1:0] csr_wr_data
);
   import spq_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;
   ram_req_type      ram_req;
   entry_type        rd_data;

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_W'(DEPTH);
      end else begin
         cap_ff <= cap_in;
      end
   end

   spq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cap     (cap_ff),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   spq_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

// File: hdl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Job table: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_ram (
   input  logic                 clock,
   input  spq_pkg::ram_req_type ram_req,
   output spq_pkg::entry_type   rd_data
);
   import spq_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= mem_ff[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the queue: walks the table one slot a cycle through a single
// priority comparator, shifting entries for insert and remove, then reads
// the head and holds the result until it is taken.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [spq_pkg::CAP_W-1:0] cap,
   spq_req_if.sink                   req,
   spq_rsp_if.source                 rsp,
   output spq_pkg::ram_req_type      ram_req,
   input  spq_pkg::entry_type        rd_data
);
   import spq_pkg::*;

   localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_INS_CMP = 7'b0000010,
      ST_INS_PUT = 7'b0000100,
      ST_REM     = 7'b0001000,
      ST_HEAD    = 7'b0010000,
      ST_CAP     = 7'b0100000,
      ST_RESP    = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   entry_type            new_ff, new_in;
   status_type           status_ff, status_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic [JOB_CNT_W-1:0] rsp_count_ff, rsp_count_in;
   entry_type            rsp_head_ff, rsp_head_in;
   logic                 full;
   logic                 moves_up;

   // effective limit is the smaller of the register and the table depth
   assign full = (CMP_W'(count_ff) >= CMP_W'(cap)) || (count_ff == CW'(DEPTH));

   // single comparator: does the stored entry sort after the new one
   assign moves_up = rd_data.prio > new_ff.prio;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      new_in        = new_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_head_in   = rsp_head_ff;
      ram_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               new_in    = '{ident: req.job_ident, prio: req.job_priority};
               status_in = STATUS_DONE;
               if (req.req_type == REQ_INSERT) begin
                  if (full) begin
                     status_in = STATUS_OVERFLOW;
                     state_in  = ST_HEAD;
                  end else if (count_ff == '0) begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = '0;
                     ram_req.wr_data = '{ident: req.job_ident, prio: req.job_priority};
                     count_in        = count_ff + CW'(1);
                     state_in        = ST_HEAD;
                  end else begin
                     idx_in          = count_ff;
                     ram_req.rd_addr = AW'(count_ff - CW'(1));
                     state_in        = ST_INS_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_UNDERFLOW;
                     state_in  = ST_HEAD;
                  end else if (count_ff == CW'(1)) begin
                     count_in = '0;
                     state_in = ST_HEAD;
                  end else begin
                     idx_in          = CW'(1);
                     ram_req.rd_addr = AW'(1);
                     state_in        = ST_REM;
                  end
               end
            end
         end

         ST_INS_CMP: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = AW'(idx_ff);
            if (moves_up) begin
               // advance the larger entry one slot and look one slot lower
               ram_req.wr_data = rd_data;
               idx_in          = idx_ff - CW'(1);
               if (idx_ff == CW'(1)) begin
                  state_in = ST_INS_PUT;
               end else begin
                  ram_req.rd_addr = AW'(idx_ff - CW'(2));
               end
            end else begin
               ram_req.wr_data = new_ff;
               count_in        = count_ff + CW'(1);
               state_in        = ST_HEAD;
            end
         end

         ST_INS_PUT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = AW'(idx_ff);
            ram_req.wr_data = new_ff;
            count_in        = count_ff + CW'(1);
            state_in        = ST_HEAD;
         end

         ST_REM: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = AW'(idx_ff - CW'(1));
            ram_req.wr_data = rd_data;
            idx_in          = idx_ff + CW'(1);
            if ((idx_ff + CW'(1)) < count_ff) begin
               ram_req.rd_addr = AW'(idx_ff + CW'(1));
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_HEAD;
            end
         end

         ST_HEAD: begin
            ram_req.rd_addr = '0;
            state_in        = ST_CAP;
         end

         ST_CAP: begin
            rsp_status_in = status_ff;
            rsp_empty_in  = (count_ff == '0);
            rsp_count_in  = JOB_CNT_W'(count_ff);
            rsp_head_in   = (count_ff == '0) ? '0 : rd_data;
            state_in      = ST_RESP;
         end

         ST_RESP: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      new_ff        <= new_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_head_ff   <= rsp_head_in;
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = (state_ff == ST_RESP);
   assign rsp.status        = rsp_status_ff;
   assign rsp.queue_empty   = rsp_empty_ff;
   assign rsp.job_count     = rsp_count_ff;
   assign rsp.head_ident    = rsp_head_ff.ident;
   assign rsp.head_priority = rsp_head_ff.prio;

endmodule

// File: hdl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  spq_pkg::status_type           rsp_status,
   input  logic                          rsp_queue_empty,
   input  logic [spq_pkg::JOB_CNT_W-1:0] rsp_job_count,
   input  logic [spq_pkg::IDENT_W-1:0]   rsp_head_ident,
   input  logic [spq_pkg::PRIO_W-1:0]    rsp_head_priority
);
   import spq_pkg::*;

   // one request in flight: never ready while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a result is pending");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_job_count)
          && $stable(rsp_head_ident) && $stable(rsp_head_priority)))
      else $error("stalled result changed");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queue_empty == (rsp_job_count == '0)))
      else $error("empty flag disagrees with count");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_queue_empty) |->
         (rsp_head_ident == '0 && rsp_head_priority == '0))
      else $error("empty queue reports a head job");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_UNDERFLOW) |-> rsp_queue_empty)
      else $error("underflow reported with jobs held");

endmodule

bind sorted_insert_priority_queue spq_checker u_spq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_queue_empty   (rsp_chan.queue_empty),
   .rsp_job_count     (rsp_chan.job_count),
   .rsp_head_ident    (rsp_chan.head_ident),
   .rsp_head_priority (rsp_chan.head_priority)
);
